// ===== rtl/core/scc_pkg.sv =====
// constants and widths for the segment to point clearance core
// no dependencies
package scc_pkg;

  localparam int COORD_BITS = 20;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int SUM_BITS   = PROD_BITS + 2;
  localparam int HALF_BITS  = SUM_BITS / 2;
  localparam int HIGH_BITS  = SUM_BITS - HALF_BITS;
  localparam int WIDE_BITS  = 2 * SUM_BITS;
  localparam int LIM_BITS   = 33;
  localparam int CMP_BITS   = SUM_BITS + 2;
  localparam int CFG_BITS   = 16;

  localparam logic CFG_SEPARATION   = 1'b0;
  localparam logic CFG_TOLERANCE_SQ = 1'b1;

  localparam logic [15:0] SEPARATION_RESET   = 16'd1280;
  localparam logic [7:0]  TOLERANCE_SQ_RESET = 8'd3;

  localparam logic [1:0] REASON_CLEAR   = 2'd0;
  localparam logic [1:0] REASON_TOO_CLOSE = 2'd1;
  localparam logic [1:0] REASON_OVERLAP = 2'd2;

  typedef struct packed {
    logic len_zero;
    logic dot_pos;
    logic dot_ge;
    logic overlap;
    logic ee_lt_oo_tol;
    logic ee_le_oo_tol;
    logic ee_lt_lim;
  } geom_flags_t;

endpackage

// ===== rtl/core/segment_circle_clearance_core.sv =====
// segment to point clearance core: streaming distance test with set reduction
// depends on scc_pkg
//
// usage
//   in channel (in_valid/in_ready) takes one beat per cycle while in_ready
//   is high: segment, point, point_valid and last. out channel (out_valid/
//   out_ready) gives one beat (clear, reason) for each input beat marked last.
//   config writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
//   must make them only while the core is idle, the core does not enforce it.
// pipeline and throughput
//   seven register stages. one beat per cycle sustained while the pipeline
//   does not stall, set by the pipeline as a whole; the wide products are
//   split into 22 by 22 partial products.
// reset
//   rst (synchronous) empties the pipeline, clears the blocked flag and first
//   reason, and reloads separation 1280 and squared tolerance 3.
// stall
//   while a result waits and out_ready is low the whole pipeline holds and
//   in_ready is low; nothing is lost or repeated.
module segment_circle_clearance_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [scc_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [scc_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [scc_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [scc_pkg::COORD_BITS-1:0] end_y,
  input  logic signed [scc_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [scc_pkg::COORD_BITS-1:0] point_y,
  input  logic                                point_valid,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                clear,
  output logic [1:0]                          reason,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [scc_pkg::CFG_BITS-1:0]        cfg_data
);

  localparam int DW = scc_pkg::DIFF_BITS;
  localparam int PW = scc_pkg::PROD_BITS;
  localparam int SW = scc_pkg::SUM_BITS;
  localparam int HB = scc_pkg::HALF_BITS;
  localparam int HH = scc_pkg::HIGH_BITS;
  localparam int WW = scc_pkg::WIDE_BITS;
  localparam int LW = scc_pkg::LIM_BITS;
  localparam int CW = scc_pkg::CMP_BITS;

  logic [15:0] separation;
  logic [7:0]  tolerance_sq;
  logic        blocked;
  logic [1:0]  first_reason;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: differences
  logic                 v1, pv1, l1;
  logic signed [DW-1:0] dx1, dy1, ox1, oy1, fx1, fy1;
  logic signed [LW-1:0] lim1;
  logic [7:0]           tol1;

  // stage 2: squares and dot terms
  logic                 v2, pv2, l2;
  logic signed [PW-1:0] dxx2, dyy2, oxx2, oyy2, fxx2, fyy2, odx2, ody2;
  logic signed [LW-1:0] lim2;
  logic [7:0]           tol2;

  // stage 3: sums
  logic                 v3, pv3, l3;
  logic [SW-1:0]        len3, oo3, ee3;
  logic signed [SW:0]   dot3;
  logic signed [LW-1:0] lim3;
  logic [7:0]           tol3;

  // stage 4: partial products and flags
  logic                 v4, pv4, l4;
  scc_pkg::geom_flags_t fl4;
  logic [2*HH-1:0]      phh4, qhh4;
  logic [HH+HB-1:0]     phl4, plh4, qhl4, qlh4;
  logic [2*HB-1:0]      pll4, qll4;
  logic [SW+7:0]        r4;

  // stage 5: full products
  logic                 v5, pv5, l5;
  scc_pkg::geom_flags_t fl5;
  logic [WW-1:0]        p5, q5, r5;

  // stage 6: decision
  logic                 v6, pv6, l6;
  logic [1:0]           why6;

  // stage 1 logic
  logic signed [DW-1:0] sx, sy, ex, ey, px, py;
  assign sx = DW'(start_x);
  assign sy = DW'(start_y);
  assign ex = DW'(end_x);
  assign ey = DW'(end_y);
  assign px = DW'(point_x);
  assign py = DW'(point_y);

  logic [31:0] sep_sq;
  assign sep_sq = separation * separation;

  // stage 4 logic
  logic signed [CW-1:0] oo_s, ee_s, lim_s, len_s, dot_s, tol_s;
  logic [SW-1:0]        dlim, dpos;
  assign oo_s  = CW'($signed({1'b0, oo3}));
  assign ee_s  = CW'($signed({1'b0, ee3}));
  assign len_s = CW'($signed({1'b0, len3}));
  assign dot_s = CW'(dot3);
  assign lim_s = CW'(lim3);
  assign tol_s = CW'($signed({1'b0, tol3}));
  assign dlim  = SW'(oo_s - lim_s);
  assign dpos  = dot3[SW-1:0];

  // stage 6 logic
  logic       b_close, b_near;
  logic [1:0] why;
  always_comb begin
    if (fl5.len_zero || !fl5.dot_pos) begin
      b_close = 1'b0;
      b_near  = 1'b0;
    end else if (fl5.dot_ge) begin
      b_close = fl5.ee_lt_oo_tol;
      b_near  = fl5.ee_lt_lim;
    end else begin
      b_close = q5 > r5;
      b_near  = p5 < q5;
    end
    if (fl5.overlap) begin
      why = (b_close || fl5.ee_le_oo_tol) ? scc_pkg::REASON_OVERLAP : scc_pkg::REASON_CLEAR;
    end else begin
      why = b_near ? scc_pkg::REASON_TOO_CLOSE : scc_pkg::REASON_CLEAR;
    end
  end

  logic       hit, blocked_next;
  logic [1:0] reason_next;
  always_comb begin
    hit          = pv6 && (why6 != scc_pkg::REASON_CLEAR) && !blocked;
    blocked_next = blocked || hit;
    reason_next  = hit ? why6 : first_reason;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      separation   <= scc_pkg::SEPARATION_RESET;
      tolerance_sq <= scc_pkg::TOLERANCE_SQ_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        scc_pkg::CFG_SEPARATION:   separation   <= cfg_data;
        scc_pkg::CFG_TOLERANCE_SQ: tolerance_sq <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      out_valid    <= 1'b0;
      blocked      <= 1'b0;
      first_reason <= scc_pkg::REASON_CLEAR;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6 && l6;
      if (v6) begin
        if (l6) begin
          blocked      <= 1'b0;
          first_reason <= scc_pkg::REASON_CLEAR;
        end else begin
          blocked      <= blocked_next;
          first_reason <= reason_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pv1  <= point_valid;
      l1   <= last;
      dx1  <= ex - sx;
      dy1  <= ey - sy;
      ox1  <= px - sx;
      oy1  <= py - sy;
      fx1  <= px - ex;
      fy1  <= py - ey;
      lim1 <= $signed({1'b0, sep_sq}) - $signed({25'd0, tolerance_sq});
      tol1 <= tolerance_sq;

      pv2  <= pv1;
      l2   <= l1;
      dxx2 <= dx1 * dx1;
      dyy2 <= dy1 * dy1;
      oxx2 <= ox1 * ox1;
      oyy2 <= oy1 * oy1;
      fxx2 <= fx1 * fx1;
      fyy2 <= fy1 * fy1;
      odx2 <= ox1 * dx1;
      ody2 <= oy1 * dy1;
      lim2 <= lim1;
      tol2 <= tol1;

      pv3  <= pv2;
      l3   <= l2;
      len3 <= SW'(dxx2) + SW'(dyy2);
      oo3  <= SW'(oxx2) + SW'(oyy2);
      ee3  <= SW'(fxx2) + SW'(fyy2);
      dot3 <= (SW+1)'(odx2) + (SW+1)'(ody2);
      lim3 <= lim2;
      tol3 <= tol2;

      pv4  <= pv3;
      l4   <= l3;
      fl4.len_zero     <= len3 == '0;
      fl4.dot_pos      <= dot_s > 0;
      fl4.dot_ge       <= dot_s >= len_s;
      fl4.overlap      <= oo_s < lim_s;
      fl4.ee_lt_oo_tol <= ee_s + tol_s < oo_s;
      fl4.ee_le_oo_tol <= ee_s <= oo_s + tol_s;
      fl4.ee_lt_lim    <= ee_s < lim_s;
      phh4 <= dlim[SW-1:HB] * len3[SW-1:HB];
      phl4 <= dlim[SW-1:HB] * len3[HB-1:0];
      plh4 <= dlim[HB-1:0] * len3[SW-1:HB];
      pll4 <= dlim[HB-1:0] * len3[HB-1:0];
      qhh4 <= dpos[SW-1:HB] * dpos[SW-1:HB];
      qhl4 <= dpos[SW-1:HB] * dpos[HB-1:0];
      qlh4 <= dpos[HB-1:0] * dpos[SW-1:HB];
      qll4 <= dpos[HB-1:0] * dpos[HB-1:0];
      r4   <= (SW+8)'(tol3) * (SW+8)'(len3);

      pv5 <= pv4;
      l5  <= l4;
      fl5 <= fl4;
      p5  <= (WW'(phh4) << (2 * HB)) + ((WW'(phl4) + WW'(plh4)) << HB) + WW'(pll4);
      q5  <= (WW'(qhh4) << (2 * HB)) + ((WW'(qhl4) + WW'(qlh4)) << HB) + WW'(qll4);
      r5  <= WW'(r4);

      pv6  <= pv5;
      l6   <= l5;
      why6 <= why;

      if (v6 && l6) begin
        clear  <= !blocked_next;
        reason <= blocked_next ? reason_next : scc_pkg::REASON_CLEAR;
      end
    end
  end

endmodule
